/* rtl/core/tcld_pkg.sv */
// Package: command codes, scanner types and helpers for the line decoder.
`timescale 1ns / 1ps
package tcld_pkg;
    localparam int LINE_CAP_DEF = 64;

    typedef enum logic [3:0] {
        CMD_HOME     = 4'd0,
        CMD_PEN_UP   = 4'd1,
        CMD_PEN_DOWN = 4'd2,
        CMD_MOVE_REL = 4'd3,
        CMD_MOVE_ABS = 4'd4,
        CMD_STATUS   = 4'd5,
        CMD_STOP     = 4'd6,
        CMD_SET_POS  = 4'd7,
        CMD_SPEED    = 4'd8,
        CMD_ENABLE   = 4'd9,
        CMD_DISABLE  = 4'd10,
        CMD_UNKNOWN  = 4'd11
    } cmd_t;

    // Argument scanner phase
    typedef enum logic [1:0] {
        SC_SKIP  = 2'd0,
        SC_DIGIT = 2'd1,
        SC_DONE  = 2'd2
    } scan_t;

    // One decoded command word as queued to the back end
    typedef struct packed {
        cmd_t        command;
        logic [31:0] arg_first;
        logic [31:0] arg_second;
        logic [31:0] arg_third;
    } word_t;

    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_CR = 8'h0D;
endpackage

/* rtl/core/tcld_front.sv */
// Front end: gathers characters, tracks keyword matches and scans arguments per byte.
`timescale 1ns / 1ps
module tcld_front #(
    parameter int LINE_CAP = tcld_pkg::LINE_CAP_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [7:0]        s_rx_byte,
    output logic              q_valid,
    input  logic              q_ready,
    output tcld_pkg::word_t   q_word
);
    import tcld_pkg::*;

    localparam int LW = $clog2(LINE_CAP);

    // Line position, clamped at LINE_CAP-1 (stored characters)
    logic [LW-1:0] len_reg, len_next;
    // Text ended by a zero byte
    logic          zend_reg, zend_next;
    // First two characters of the text (zero if absent)
    logic [7:0]    c0_reg, c0_next, c1_reg, c1_next;
    // Exact-word match flags, each valid while text length is in range
    logic [5:0]    kw_reg, kw_next;  // HOME, PEN 0, PEN 1, STATUS, STOP, pad
    // Scanner
    scan_t         sc_reg, sc_next;
    logic          neg_reg, neg_next;
    logic [31:0]   acc_reg, acc_next;
    logic [1:0]    ai_reg, ai_next;
    logic [31:0]   a_reg [3];
    logic [31:0]   a_next [3];
    // Text length: count of characters before any zero byte
    logic [LW-1:0] tcnt_reg, tcnt_next;

    logic [7:0] b;
    logic       is_eol, take, gone;
    logic [31:0] acc_mul;
    logic [31:0] fin;
    logic [1:0]  lim;
    word_t       w;

    assign b      = s_rx_byte;
    assign is_eol = (b == CH_LF) || (b == CH_CR);
    assign s_ready = !is_eol || !q_valid || q_ready || (len_reg == '0);
    assign take   = s_valid && s_ready;
    // A character counts for matching only if stored and before a zero byte
    assign gone   = zend_reg || (len_reg == LW'(LINE_CAP - 1));
    assign acc_mul = {acc_reg[28:0], 3'b000} + {acc_reg[30:0], 1'b0};
    assign fin     = neg_reg ? (32'd0 - acc_reg) : acc_reg;

    function automatic logic tlen_is(input int n);
        tlen_is = (tcnt_reg == LW'(n));
    endfunction

    // Character of keyword k at position p
    function automatic logic [7:0] kch(input int k, input logic [LW-1:0] p);
        logic [47:0] s;
        begin
            case (k)
                0: s = {"HOME", 16'h0};
                1: s = {"PEN 0", 8'h0};
                2: s = {"PEN 1", 8'h0};
                3: s = "STATUS";
                default: s = {"STOP", 16'h0};
            endcase
            if (p > LW'(5)) kch = 8'h00;
            else kch = s[47 - 8 * int'(p) -: 8];
        end
    endfunction

    // Per-character update of classification and scan
    always_comb begin
        len_next = len_reg; zend_next = zend_reg;
        c0_next = c0_reg; c1_next = c1_reg; kw_next = kw_reg;
        sc_next = sc_reg; neg_next = neg_reg; acc_next = acc_reg; ai_next = ai_reg;
        a_next = a_reg;
        lim = 2'd0;
        if (c0_reg == "M" || c0_reg == "A") lim = 2'd3;
        else if (c0_reg == "S" && c1_reg == "P") lim = 2'd2;
        else if (c0_reg == "V" || c0_reg == "E") lim = 2'd1;
        if (take && !is_eol && !gone) begin
            len_next = len_reg + 1'b1;
            if (b == 8'h00) begin
                zend_next = 1'b1;
            end else begin
                if (len_reg == '0) c0_next = b;
                if (len_reg == LW'(1)) c1_next = b;
                for (int k = 0; k < 5; k++)
                    if (b != kch(k, len_reg)) kw_next[k] = 1'b0;
                // Scanner starts after the prefix
                if ((len_reg >= LW'(1) && (c0_reg == "M" || c0_reg == "A"
                        || c0_reg == "V" || c0_reg == "E")) ||
                    (len_reg >= LW'(2) && c0_reg == "S" && c1_reg == "P")) begin
                    if (ai_reg < lim) begin
                        case (sc_reg)
                            SC_SKIP: begin
                                if (b == " " || b == 8'h09) begin
                                end else if (b == "-") begin
                                    neg_next = 1'b1; sc_next = SC_DIGIT;
                                end else if (b == "+") begin
                                    sc_next = SC_DIGIT;
                                end else if (b >= "0" && b <= "9") begin
                                    acc_next = {28'd0, b[3:0]}; sc_next = SC_DIGIT;
                                end else begin
                                    sc_next = SC_DONE;
                                end
                            end
                            SC_DIGIT: begin
                                if (b >= "0" && b <= "9") begin
                                    acc_next = acc_mul + {28'd0, b[3:0]};
                                end else begin
                                    // Argument ends; this byte starts the next scan
                                    a_next[ai_reg] = fin;
                                    ai_next = ai_reg + 2'd1;
                                    neg_next = 1'b0; acc_next = '0;
                                    sc_next = SC_SKIP;
                                    if (b == " " || b == 8'h09) begin
                                    end else if (b == "-") begin
                                        neg_next = 1'b1; sc_next = SC_DIGIT;
                                    end else if (b == "+") begin
                                        sc_next = SC_DIGIT;
                                    end else if (b >= "0" && b <= "9") begin
                                        acc_next = {28'd0, b[3:0]};
                                        sc_next = SC_DIGIT;
                                    end else begin
                                        sc_next = SC_DONE;
                                    end
                                end
                            end
                            default: begin
                                // Stuck: remaining arguments scan to zero
                            end
                        endcase
                    end
                end
            end
        end
        if (take && is_eol) begin
            len_next = '0; zend_next = 1'b0; c0_next = 8'h00; c1_next = 8'h00;
            kw_next = '1; sc_next = SC_SKIP; neg_next = 1'b0; acc_next = '0;
            ai_next = 2'd0;
            for (int i = 0; i < 3; i++) a_next[i] = '0;
        end
    end

    // Decode at end of line
    always_comb begin
        logic [31:0] aa [3];
        logic [LW-1:0] tl;
        aa = a_reg;
        if (sc_reg == SC_DIGIT && ai_reg < lim) aa[ai_reg] = fin;
        for (int i = 0; i < 3; i++)
            if (2'(i) >= lim) aa[i] = '0;
        // text length equals stored count unless a zero byte came earlier
        tl = len_reg;
        w.command = CMD_UNKNOWN;
        w.arg_first = '0; w.arg_second = '0; w.arg_third = '0;
        if ((c0_reg == "H" && c1_reg == 8'h00) || (kw_reg[0] && tlen_is(4)))
            w.command = CMD_HOME;
        else if ((c0_reg == "P" && c1_reg == "0" && tlen_is(2)) || (kw_reg[1] && tlen_is(5)))
            w.command = CMD_PEN_UP;
        else if ((c0_reg == "P" && c1_reg == "1" && tlen_is(2)) || (kw_reg[2] && tlen_is(5)))
            w.command = CMD_PEN_DOWN;
        else if (c0_reg == "M" || c0_reg == "A") begin
            w.command = (c0_reg == "M") ? CMD_MOVE_REL : CMD_MOVE_ABS;
            w.arg_first = aa[0]; w.arg_second = aa[1]; w.arg_third = aa[2];
        end else if ((c0_reg == "Q" && c1_reg == 8'h00) || (kw_reg[3] && tlen_is(6)))
            w.command = CMD_STATUS;
        else if ((c0_reg == "!" && c1_reg == 8'h00) || (kw_reg[4] && tlen_is(4)))
            w.command = CMD_STOP;
        else if (c0_reg == "S" && c1_reg == "P") begin
            w.command = CMD_SET_POS;
            w.arg_first = aa[0]; w.arg_second = aa[1];
        end else if (c0_reg == "V") begin
            w.command = CMD_SPEED; w.arg_first = aa[0];
        end else if (c0_reg == "E") begin
            w.arg_first = aa[0];
            w.command = (aa[0] != '0) ? CMD_ENABLE : CMD_DISABLE;
        end
        if (tl == '0) w.command = CMD_UNKNOWN;
    end

    // Text length count
    always_comb begin
        tcnt_next = tcnt_reg;
        if (take && !is_eol && !gone && b != 8'h00) tcnt_next = tcnt_reg + 1'b1;
        if (take && is_eol) tcnt_next = '0;
    end

    // State registers and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg <= '0; zend_reg <= 1'b0; c0_reg <= 8'h00; c1_reg <= 8'h00;
            kw_reg <= '1; sc_reg <= SC_SKIP; neg_reg <= 1'b0; acc_reg <= '0;
            ai_reg <= 2'd0; tcnt_reg <= '0; q_valid <= 1'b0;
            for (int i = 0; i < 3; i++) a_reg[i] <= '0;
        end else begin
            len_reg <= len_next; zend_reg <= zend_next; c0_reg <= c0_next;
            c1_reg <= c1_next; kw_reg <= kw_next; sc_reg <= sc_next;
            neg_reg <= neg_next; acc_reg <= acc_next; ai_reg <= ai_next;
            tcnt_reg <= tcnt_next; a_reg <= a_next;
            if (q_ready) q_valid <= 1'b0;
            if (take && is_eol && len_reg != '0) begin
                q_valid <= 1'b1;
                q_word  <= w;
            end
        end
    end
endmodule

/* rtl/core/tcld_back.sv */
// Back end: two-entry queue that delivers decoded command words.
`timescale 1ns / 1ps
module tcld_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             q_valid,
    output logic             q_ready,
    input  tcld_pkg::word_t  q_word,
    output logic             m_valid,
    input  logic             m_ready,
    output tcld_pkg::word_t  m_word
);
    import tcld_pkg::*;

    word_t      mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;

    assign q_ready = (cnt_reg != 2'd2);
    assign m_valid = (cnt_reg != 2'd0);
    assign m_word  = mem_reg[rp_reg];

    // Queue pointers and storage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= 1'b0; rp_reg <= 1'b0; cnt_reg <= 2'd0;
        end else begin
            if (q_valid && q_ready) begin
                mem_reg[wp_reg] <= q_word;
                wp_reg <= ~wp_reg;
            end
            if (m_valid && m_ready) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(q_valid && q_ready) - 2'(m_valid && m_ready);
        end
    end
endmodule

/* rtl/core/text_command_line_decoder.sv */
// Top level of the text command line decoder.
//
// s_ channel: one received byte per word (s_rx_byte), valid/ready.
// m_ channel: one decoded command per non-empty line: m_command and three
// signed 32-bit arguments, valid/ready.
// Characters are classified and scanned as they arrive, one byte per cycle
// unless stalled; the line is never re-read. A CR or LF that ends a non-empty
// line loads a result register at its accepting edge; the word then moves
// into a two-word queue when the queue has room, and m_valid rises once it
// is in the queue.
// Throughput, set by the per-byte scanner stage, is one byte per cycle unless stalled.
// Reset (aresetn low, synchronous) clears the line and empties the queue.
// When the receiver stalls, the queue and then the result register fill; after that
// only end-of-line bytes of non-empty lines wait, other bytes keep flowing.
`timescale 1ns / 1ps
module text_command_line_decoder #(
    parameter int LINE_CAP = tcld_pkg::LINE_CAP_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_command,
    output logic signed [31:0] m_arg_first,
    output logic signed [31:0] m_arg_second,
    output logic signed [31:0] m_arg_third
);
    import tcld_pkg::*;

    logic  q_valid, q_ready;
    word_t q_word, m_word;

    tcld_front #(.LINE_CAP(LINE_CAP)) u_front (
        .aclk, .aresetn, .s_valid, .s_ready, .s_rx_byte,
        .q_valid, .q_ready, .q_word
    );

    tcld_back u_back (
        .aclk, .aresetn, .q_valid, .q_ready, .q_word,
        .m_valid, .m_ready, .m_word
    );

    assign m_command    = m_word.command;
    assign m_arg_first  = m_word.arg_first;
    assign m_arg_second = m_word.arg_second;
    assign m_arg_third  = m_word.arg_third;
endmodule

/* rtl/core/tcld_checker.sv */
// Port-level checker for the line decoder, bound to the top level.
`timescale 1ns / 1ps
module tcld_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic [7:0]  s_rx_byte,
    input logic        m_valid,
    input logic        m_ready,
    input logic [3:0]  m_command
);
    // Command code in range
    a_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_command <= 4'd11)) else $error("bad command code");
    // Ordinary characters are never stalled
    a_char: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_rx_byte != 8'h0A && s_rx_byte != 8'h0D) |-> s_ready)
        else $error("character stalled");
    // Output command holds while stalled
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_command)))
        else $error("output changed while stalled");
    // No output right after reset
    a_rst: assert property (@(posedge aclk)
        !aresetn |=> !m_valid) else $error("output after reset");
endmodule

bind text_command_line_decoder tcld_checker u_chk (
    .aclk, .aresetn, .s_valid, .s_ready, .s_rx_byte, .m_valid, .m_ready, .m_command
);
